/* rtl/jsu_pkg.sv */
// jsu_pkg: shared types, status codes and character constants for the JSON string unescaper.
// No dependencies.
package jsu_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int GRP_MAX  = 4;
   localparam int CNT_W    = 3;

   localparam logic [STATUS_W-1:0] ST_DATA    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DONE    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOQUOTE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CTRL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ESC     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_HEX     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_SURR    = 3'd6;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_HT = 8'h09;

   // top six bits of high (D800..DBFF) and low (DC00..DFFF) surrogates
   localparam logic [5:0] HI_SURR_TAG = 6'h36;
   localparam logic [5:0] LO_SURR_TAG = 6'h37;

   localparam logic [15:0] CP_MAX_1B = 16'h007F;
   localparam logic [15:0] CP_MAX_2B = 16'h07FF;

   typedef struct packed {
      logic [CNT_W-1:0]               cnt;
      logic [STATUS_W-1:0]            status;
      logic [GRP_MAX-1:0][BYTE_W-1:0] bytes;
   } jsu_grp_type;

   // bit 4 set when the byte is a hex digit, bits 3:0 its value
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      return r;
   endfunction

endpackage

/* rtl/jsu_req_if.sv */
// jsu_req_if: input byte channel, valid/ready with the JSON text byte.
// Depends on jsu_pkg.
interface jsu_req_if import jsu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

/* rtl/jsu_rsp_if.sv */
// jsu_rsp_if: result channel, valid/ready with decoded byte, status and last flag.
// Depends on jsu_pkg.
interface jsu_rsp_if import jsu_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output out_byte, output status, output last, input ready);
   modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

/* rtl/jsu_decode.sv */
// jsu_decode: string parser state and single-pass decode of one byte into a result group.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [BYTE_W-1:0] in_byte,
   output jsu_grp_type       grp
);

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_STR     = 7'b0000010,
      PH_ESC     = 7'b0000100,
      PH_HEX     = 7'b0001000,
      PH_PAIR_BS = 7'b0010000,
      PH_PAIR_U  = 7'b0100000,
      PH_HEX_LOW = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [15:0] cp_ff, cp_in;
   logic [9:0]  hs_ff, hs_in;

   logic [4:0]  hv;
   logic [15:0] cp_next;

   function automatic jsu_grp_type one_result(input logic [7:0] b, input logic [2:0] st);
      jsu_grp_type g;
      g          = '0;
      g.cnt      = 3'd1;
      g.status   = st;
      g.bytes[0] = b;
      return g;
   endfunction

   function automatic jsu_grp_type encode16(input logic [15:0] cp);
      jsu_grp_type g;
      g = '0;
      if (cp <= CP_MAX_1B) begin
         g.cnt      = 3'd1;
         g.bytes[0] = cp[7:0];
      end else if (cp <= CP_MAX_2B) begin
         g.cnt      = 3'd2;
         g.bytes[0] = {3'b110, cp[10:6]};
         g.bytes[1] = {2'b10, cp[5:0]};
      end else begin
         g.cnt      = 3'd3;
         g.bytes[0] = {4'b1110, cp[15:12]};
         g.bytes[1] = {2'b10, cp[11:6]};
         g.bytes[2] = {2'b10, cp[5:0]};
      end
      return g;
   endfunction

   // hs: high surrogate minus D800, lo: low surrogate minus DC00
   function automatic jsu_grp_type encode_pair(input logic [9:0] hs, input logic [9:0] lo);
      jsu_grp_type g;
      logic [4:0]  plane;
      g          = '0;
      plane      = {1'b0, hs[9:6]} + 5'd1;
      g.cnt      = 3'd4;
      g.bytes[0] = {5'b11110, plane[4:2]};
      g.bytes[1] = {2'b10, plane[1:0], hs[5:2]};
      g.bytes[2] = {2'b10, hs[1:0], lo[9:6]};
      g.bytes[3] = {2'b10, lo[5:0]};
      return g;
   endfunction

   assign hv      = hex_value(in_byte);
   assign cp_next = {cp_ff[11:0], hv[3:0]};

   always_comb begin
      phase_in   = phase_ff;
      hex_cnt_in = hex_cnt_ff;
      cp_in      = cp_ff;
      hs_in      = hs_ff;
      grp        = '0;
      case (phase_ff)
         PH_STR: begin
            if (in_byte == CH_NUL) begin
               grp = one_result(CH_NUL, ST_NOQUOTE);
               phase_in = PH_IDLE; hex_cnt_in = '0;
            end else if (in_byte == CH_QUOTE) begin
               grp = one_result(CH_NUL, ST_DONE);
               phase_in = PH_IDLE; hex_cnt_in = '0;
            end else if (in_byte < CH_SPACE) begin
               grp = one_result(CH_NUL, ST_CTRL);
               phase_in = PH_IDLE; hex_cnt_in = '0;
            end else if (in_byte == CH_BSLASH) begin
               phase_in = PH_ESC;
            end else begin
               grp = one_result(in_byte, ST_DATA);
            end
         end
         PH_ESC: begin
            phase_in = PH_STR;
            case (in_byte)
               CH_QUOTE, CH_BSLASH, CH_SLASH: grp = one_result(in_byte, ST_DATA);
               CH_B: grp = one_result(CTL_BS, ST_DATA);
               CH_F: grp = one_result(CTL_FF, ST_DATA);
               CH_N: grp = one_result(CTL_LF, ST_DATA);
               CH_R: grp = one_result(CTL_CR, ST_DATA);
               CH_T: grp = one_result(CTL_HT, ST_DATA);
               CH_U: begin
                  phase_in = PH_HEX; hex_cnt_in = '0; cp_in = '0;
               end
               default: begin
                  grp = one_result(CH_NUL, ST_ESC);
                  phase_in = PH_IDLE; hex_cnt_in = '0;
               end
            endcase
         end
         PH_HEX, PH_HEX_LOW: begin
            if (!hv[4]) begin
               grp = one_result(CH_NUL, ST_HEX);
               phase_in = PH_IDLE; hex_cnt_in = '0;
            end else begin
               cp_in      = cp_next;
               hex_cnt_in = hex_cnt_ff + 2'd1;
               if (hex_cnt_ff == 2'd3) begin
                  if (phase_ff == PH_HEX) begin
                     if (cp_next[15:10] == HI_SURR_TAG) begin
                        hs_in    = cp_next[9:0];
                        phase_in = PH_PAIR_BS;
                     end else begin
                        grp      = encode16(cp_next);
                        phase_in = PH_STR;
                     end
                  end else if (cp_next[15:10] != LO_SURR_TAG) begin
                     grp = one_result(CH_NUL, ST_SURR);
                     phase_in = PH_IDLE;
                  end else begin
                     grp      = encode_pair(hs_ff, cp_next[9:0]);
                     phase_in = PH_STR;
                  end
               end
            end
         end
         PH_PAIR_BS: begin
            if (in_byte != CH_BSLASH) begin
               grp = one_result(CH_NUL, ST_SURR);
               phase_in = PH_IDLE; hex_cnt_in = '0;
            end else begin
               phase_in = PH_PAIR_U;
            end
         end
         PH_PAIR_U: begin
            if (in_byte != CH_U) begin
               grp = one_result(CH_NUL, ST_SURR);
               phase_in = PH_IDLE; hex_cnt_in = '0;
            end else begin
               phase_in = PH_HEX_LOW; hex_cnt_in = '0; cp_in = '0;
            end
         end
         default: begin
            phase_in = (in_byte == CH_QUOTE) ? PH_STR : PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         hex_cnt_ff <= '0;
         cp_ff      <= '0;
         hs_ff      <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         hex_cnt_ff <= hex_cnt_in;
         cp_ff      <= cp_in;
         hs_ff      <= hs_in;
      end
   end

endmodule

/* rtl/jsu_out_buf.sv */
// jsu_out_buf: result group register, hands out up to four results one per cycle
// while rsp_ready is high. Depends on jsu_pkg.
module jsu_out_buf import jsu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  jsu_grp_type         grp,
   input  logic                rsp_ready,
   output logic                free,
   output logic                rsp_valid,
   output logic [BYTE_W-1:0]   out_byte,
   output logic [STATUS_W-1:0] status,
   output logic                last
);

   logic [GRP_MAX-1:0][BYTE_W-1:0] bytes_ff;
   logic [STATUS_W-1:0]            status_ff;
   logic [CNT_W-1:0]               rem_ff;
   logic [1:0]                     idx_ff;

   assign rsp_valid = (rem_ff != '0);
   assign last      = (rem_ff == CNT_W'(1));
   assign free      = !rsp_valid || (last && rsp_ready);
   assign out_byte  = bytes_ff[idx_ff];
   assign status    = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         idx_ff <= '0;
      end else if (load) begin
         rem_ff <= grp.cnt;
         idx_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         rem_ff <= rem_ff - CNT_W'(1);
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff  <= grp.bytes;
         status_ff <= grp.status;
      end
   end

endmodule

/* rtl/json_string_unescape.sv */
// json_string_unescape: JSON string literal to UTF-8 decoder, top level.
// Depends on jsu_pkg, jsu_req_if, jsu_rsp_if, jsu_decode, jsu_out_buf.
//
//   channel  dir  signals                          transfer
//   req_if   in   valid ready in_byte              one JSON text byte
//   rsp_if   out  valid ready out_byte status last one decoded byte or status
//
// A byte is taken every cycle unless held; a registered byte is decoded in one
// pass into a group of zero to four results, and the group register hands out
// one result a cycle while rsp ready is high; a byte with results waits for it.
// A req byte passes the input register, then the group register, to its rsp.
// Synchronous reset clears the parser phase and both valid stages.
// Bytes yielding no result pass through even while the group register is busy.
module json_string_unescape import jsu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   jsu_req_if.sink      req_if,
   jsu_rsp_if.source    rsp_if
);

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   jsu_grp_type       grp;
   logic              buf_free;
   logic              advance;
   logic              load;

   assign advance      = in_valid_ff && ((grp.cnt == '0) || buf_free);
   assign load         = advance && (grp.cnt != '0);
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.in_byte;
      end
   end

   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .in_byte (in_byte_ff),
      .grp     (grp)
   );

   jsu_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .grp       (grp),
      .rsp_ready (rsp_if.ready),
      .free      (buf_free),
      .rsp_valid (rsp_if.valid),
      .out_byte  (rsp_if.out_byte),
      .status    (rsp_if.status),
      .last      (rsp_if.last)
   );

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ST_DATA) |-> rsp_if.last)
      else $error("status result not marked last");

   a_status_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ST_DATA) |-> (rsp_if.out_byte == '0))
      else $error("status result carries non-zero byte");

   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && !rsp_if.last) |=> rsp_if.valid)
      else $error("result group cut short");

   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (in_valid_ff && rsp_if.valid))
      else $error("input stalled without pending work");

endmodule
